// ===== rtl/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg: shared types and tables for the line highlight classifier
// Highlight classes, scan modes, the keyword table and the word matching
// functions used by the scanner.
// ----------------------------------------------------------------------------
package csh_pkg;

  localparam int MAX_WORD  = 63;
  localparam int WLEN_W    = $clog2(MAX_WORD + 1);
  localparam int NUM_KEYS  = 15;
  localparam int NUM_TYPES = 7;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef logic [NUM_KEYS-1:0] cand_t;
  typedef logic [WLEN_W-1:0]   wlen_t;

  localparam cand_t ALL_KEYS = '1;

  typedef enum logic [2:0] {
    CLS_TEXT    = 3'd0,
    CLS_TYPE    = 3'd1,
    CLS_CONTROL = 3'd2,
    CLS_STRING  = 3'd3,
    CLS_NUMBER  = 3'd4,
    CLS_COMMENT = 3'd5
  } cls_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_t;

  // Results of one transfer, in order: a held word, up to two single
  // classes, then a word that completes within this transfer.
  typedef struct packed {
    wlen_t      n_old;
    cls_t       cls_old;
    logic [1:0] s_cnt;
    cls_t       s0;
    cls_t       s1;
    wlen_t      n_new;
    cls_t       cls_new;
    logic       line_end;
  } plan_t;

  // Keyword text, right-justified: the first character sits in the highest
  // used byte.
  localparam logic [63:0] KEY_TEXT [NUM_KEYS] = '{
    64'("int"), 64'("char"), 64'("void"), 64'({"uint32", "_t"}), 64'("uint8_t"),
    64'("size_t"), 64'("float"), 64'("if"), 64'("else"), 64'("while"),
    64'("for"), 64'("return"), 64'("struct"), 64'("include"), 64'("define")
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
    4'd3, 4'd4, 4'd4, 4'd8, 4'd7, 4'd6, 4'd5,
    4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd6, 4'd7, 4'd6
  };

  // Drop the keywords that do not have character c at position pos.
  function automatic cand_t match_step(cand_t cand, wlen_t pos, logic [7:0] c);
    cand_t res;
    int    sh;
    res = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (cand[k] && (int'(pos) < int'(KEY_LEN[k]))) begin
        sh = 8 * (int'(KEY_LEN[k]) - 1 - int'(pos));
        res[k] = (KEY_TEXT[k][sh +: 8] == c);
      end
    end
    return res;
  endfunction

  // The first keyword still matching with exactly len characters decides.
  function automatic cls_t flush_class(cand_t cand, wlen_t len);
    cls_t cls;
    logic found;
    cls   = CLS_TEXT;
    found = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!found && cand[k] && (len == WLEN_W'(KEY_LEN[k]))) begin
        cls   = (k < NUM_TYPES) ? CLS_TYPE : CLS_CONTROL;
        found = 1'b1;
      end
    end
    return cls;
  endfunction

endpackage

// ===== rtl/c_syntax_highlight_classifier.sv =====
// ----------------------------------------------------------------------------
// c_syntax_highlight_classifier: per-character highlight classes for C lines
// Gives each character of a source line a class: text, type keyword,
// control keyword, string, number or comment.
// ----------------------------------------------------------------------------
// Input channel: char_code and line_end with in_valid / in_stall. Set
// line_end on the final character of a line; it flushes all held characters
// and returns the scanner to its idle state.
// Output channel: char_class, line_done and last with out_valid / out_stall.
// Results come in character order; last marks the final result caused by
// one input transfer, line_done the result of the line's final character.
// A character may cause no result (word characters and a lone slash are
// held) or up to 63 when a word is flushed.
// Timing: an accepted transfer's plan is registered in the sequencer, and
// its results then pass through the output register, one result per cycle
// while the receiver does not stall. The sequencer holds in_stall until its
// plan is empty, so a new input is not accepted while results of the last
// one are pending; an input causing none does not hold in_stall. A stalled
// output holds its result; the sequencer waits with it.
// Reset clears the scan state, the pending plan and out_valid.
// ----------------------------------------------------------------------------
module c_syntax_highlight_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] char_class,
  output logic       line_done,
  output logic       last
);

  csh_pkg::plan_t plan;
  logic           busy;
  logic           accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  csh_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .line_end  (line_end),
    .plan      (plan)
  );

  csh_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .plan_in    (plan),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_class (char_class),
    .line_done  (line_done),
    .last       (last)
  );

endmodule

// ===== rtl/csh_scanner.sv =====
// ----------------------------------------------------------------------------
// csh_scanner: scan state and result plan
// Holds the scan mode, the word being collected and the pending slash, and
// works out for each accepted character the run of classes it releases.
// ----------------------------------------------------------------------------
module csh_scanner (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     char_code,
  input  logic           line_end,
  output csh_pkg::plan_t plan
);

  csh_pkg::mode_t mode, mode_next;
  csh_pkg::wlen_t word_length, word_length_next;
  csh_pkg::cand_t cands, cands_next;
  logic           slash_pending, slash_pending_next;

  // What a character does when it starts afresh.
  csh_pkg::mode_t fresh_mode;
  logic           fresh_single;
  csh_pkg::cls_t  fresh_cls;
  logic           fresh_slash;
  logic           fresh_word;
  csh_pkg::cand_t first_cands;
  csh_pkg::cand_t add_cands;
  csh_pkg::wlen_t add_len;

  logic is_letter, is_decimal;

  assign is_letter  = (char_code >= 8'h61 && char_code <= 8'h7A) ||
                      (char_code >= 8'h41 && char_code <= 8'h5A) ||
                      (char_code == csh_pkg::CH_UNDER);
  assign is_decimal = (char_code >= 8'h30 && char_code <= 8'h39);

  assign first_cands = csh_pkg::match_step(csh_pkg::ALL_KEYS, '0, char_code);
  assign add_cands   = csh_pkg::match_step(cands, word_length, char_code);
  assign add_len     = word_length + csh_pkg::wlen_t'(1);

  always_comb begin
    fresh_mode   = csh_pkg::MODE_IDLE;
    fresh_single = 1'b0;
    fresh_cls    = csh_pkg::CLS_TEXT;
    fresh_slash  = 1'b0;
    fresh_word   = 1'b0;
    priority if (char_code == csh_pkg::CH_SLASH) begin
      // A slash on the final character has no successor and is text.
      fresh_single = line_end;
      fresh_slash  = !line_end;
    end else if (char_code == csh_pkg::CH_QUOTE) begin
      fresh_single = 1'b1;
      fresh_cls    = csh_pkg::CLS_STRING;
      fresh_mode   = csh_pkg::MODE_STRING;
    end else if (is_letter) begin
      fresh_word   = 1'b1;
      fresh_mode   = csh_pkg::MODE_WORD;
    end else if (is_decimal) begin
      fresh_single = 1'b1;
      fresh_cls    = csh_pkg::CLS_NUMBER;
      fresh_mode   = csh_pkg::MODE_NUMBER;
    end else begin
      fresh_single = 1'b1;
    end
  end

  always_comb begin
    logic use_fresh;
    logic second;
    use_fresh          = 1'b0;
    second             = 1'b0;
    plan               = '0;
    plan.cls_old       = csh_pkg::CLS_TEXT;
    plan.s0            = csh_pkg::CLS_TEXT;
    plan.s1            = csh_pkg::CLS_TEXT;
    plan.cls_new       = csh_pkg::CLS_TEXT;
    plan.line_end      = line_end;
    mode_next          = mode;
    word_length_next   = word_length;
    cands_next         = cands;
    slash_pending_next = 1'b0;

    if (slash_pending) begin
      if (char_code == csh_pkg::CH_SLASH) begin
        plan.s_cnt = 2'd2;
        plan.s0    = csh_pkg::CLS_COMMENT;
        plan.s1    = csh_pkg::CLS_COMMENT;
        mode_next  = csh_pkg::MODE_COMMENT;
      end else begin
        plan.s_cnt = 2'd1;
        plan.s0    = csh_pkg::CLS_TEXT;
        use_fresh  = 1'b1;
        second     = 1'b1;
      end
    end else begin
      unique case (mode)
        csh_pkg::MODE_COMMENT: begin
          plan.s_cnt = 2'd1;
          plan.s0    = csh_pkg::CLS_COMMENT;
        end
        csh_pkg::MODE_STRING: begin
          plan.s_cnt = 2'd1;
          plan.s0    = csh_pkg::CLS_STRING;
          if (char_code == csh_pkg::CH_QUOTE) mode_next = csh_pkg::MODE_IDLE;
        end
        csh_pkg::MODE_NUMBER: begin
          if (is_decimal || char_code == csh_pkg::CH_DOT) begin
            plan.s_cnt = 2'd1;
            plan.s0    = csh_pkg::CLS_NUMBER;
          end else begin
            use_fresh = 1'b1;
          end
        end
        csh_pkg::MODE_WORD: begin
          if (is_letter || is_decimal) begin
            if (add_len >= csh_pkg::wlen_t'(csh_pkg::MAX_WORD) || line_end) begin
              plan.n_new       = add_len;
              plan.cls_new     = csh_pkg::flush_class(add_cands, add_len);
              mode_next        = csh_pkg::MODE_IDLE;
              word_length_next = '0;
              cands_next       = csh_pkg::ALL_KEYS;
            end else begin
              word_length_next = add_len;
              cands_next       = add_cands;
            end
          end else begin
            plan.n_old   = word_length;
            plan.cls_old = csh_pkg::flush_class(cands, word_length);
            use_fresh    = 1'b1;
          end
        end
        default: use_fresh = 1'b1;
      endcase
    end

    if (use_fresh) begin
      mode_next          = fresh_mode;
      slash_pending_next = fresh_slash;
      if (fresh_single) begin
        if (second) begin
          plan.s_cnt = 2'd2;
          plan.s1    = fresh_cls;
        end else begin
          plan.s_cnt = 2'd1;
          plan.s0    = fresh_cls;
        end
      end
      if (fresh_word) begin
        // A word never ends on its first character unless the line does.
        if (line_end) begin
          plan.n_new   = csh_pkg::wlen_t'(1);
          plan.cls_new = csh_pkg::flush_class(first_cands, csh_pkg::wlen_t'(1));
        end
        word_length_next = csh_pkg::wlen_t'(1);
        cands_next       = first_cands;
      end
    end

    if (line_end) begin
      mode_next          = csh_pkg::MODE_IDLE;
      word_length_next   = '0;
      cands_next         = csh_pkg::ALL_KEYS;
      slash_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= csh_pkg::MODE_IDLE;
      word_length   <= '0;
      cands         <= csh_pkg::ALL_KEYS;
      slash_pending <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      word_length   <= word_length_next;
      cands         <= cands_next;
      slash_pending <= slash_pending_next;
    end
  end

endmodule

// ===== rtl/csh_emitter.sv =====
// ----------------------------------------------------------------------------
// csh_emitter: result sequencer
// Takes the plan of one character and counts it out, one class per cycle
// while the output does not stall, through the output register.
// ----------------------------------------------------------------------------
module csh_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  csh_pkg::plan_t plan_in,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     char_class,
  output logic           line_done,
  output logic           last
);

  csh_pkg::plan_t plan;
  logic           slot_free;
  logic [csh_pkg::WLEN_W:0] remaining;
  csh_pkg::cls_t  next_cls;

  assign busy      = (plan.n_old != '0) || (plan.s_cnt != '0) || (plan.n_new != '0);
  assign slot_free = !out_valid || !out_stall;
  assign remaining = {1'b0, plan.n_old} + {1'b0, plan.n_new} +
                     (csh_pkg::WLEN_W + 1)'(plan.s_cnt);

  always_comb begin
    priority if (plan.n_old != '0) begin
      next_cls = plan.cls_old;
    end else if (plan.s_cnt != '0) begin
      next_cls = plan.s0;
    end else begin
      next_cls = plan.cls_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plan.n_old <= '0;
      plan.s_cnt <= '0;
      plan.n_new <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        plan <= plan_in;
      end else if (busy && slot_free) begin
        priority if (plan.n_old != '0) begin
          plan.n_old <= plan.n_old - csh_pkg::wlen_t'(1);
        end else if (plan.s_cnt != '0) begin
          plan.s_cnt <= plan.s_cnt - 2'd1;
          plan.s0    <= plan.s1;
        end else begin
          plan.n_new <= plan.n_new - csh_pkg::wlen_t'(1);
        end
      end
      if (slot_free) out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && slot_free) begin
      char_class <= next_cls;
      last       <= (remaining == (csh_pkg::WLEN_W + 1)'(1));
      line_done  <= (remaining == (csh_pkg::WLEN_W + 1)'(1)) && plan.line_end;
    end
  end

endmodule

// ===== rtl/csh_checker.sv =====
// ----------------------------------------------------------------------------
// csh_checker: port-level checks for the highlight classifier
// Watches the top level's ports and flags results that break the output
// rules and stalled input transfers that change their payload.
// ----------------------------------------------------------------------------
module csh_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] char_code,
  input logic       line_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] char_class,
  input logic       line_done,
  input logic       last
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_class) &&
                               $stable(line_done) && $stable(last))
    else $error("stalled result changed");

  // A stalled input transfer keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(line_end))
    else $error("stalled input changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> last)
    else $error("line_done without last");

  a_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_class <= csh_pkg::CLS_COMMENT))
    else $error("undefined highlight class");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind c_syntax_highlight_classifier csh_checker u_csh_checker (.*);
